// ===== design/sca_pkg.sv =====
`timescale 1ns / 1ps
// Package for the size class block allocator: types, class tables and sequencer states.
// It has no dependencies. The divider and the top level use it.
package sca_pkg;

    localparam int POOL_PAGES   = 64;
    localparam int PAGE_W       = 6;
    localparam int SLOT_W       = 8;
    localparam int OFFSET_W     = 12;
    localparam int ADDR_W       = 18;
    localparam int SIZE_CLASSES = 8;
    localparam int CLASS_W      = 3;
    localparam int BYTES_W      = 11;
    localparam int RECIP_W      = 21;
    localparam int RECIP_SHIFT  = 24;

    localparam logic [6:0] NO_PAGE   = 7'd64;
    localparam logic [7:0] NO_SLOT   = 8'd255;
    localparam logic [11:0] SLOT_BASE = 12'd16;

    localparam logic [BYTES_W-1:0] CLASS_BYTES [SIZE_CLASSES] = '{
        11'd16, 11'd32, 11'd64, 11'd128, 11'd248, 11'd504, 11'd1016, 11'd2040
    };

    // Reciprocal of each class size, rounded up and scaled by two to the RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] CLASS_RECIP [SIZE_CLASSES] = '{
        21'd1048576, 21'd524288, 21'd262144, 21'd131072,
        21'd67651, 21'd33289, 21'd16514, 21'd8225
    };

    // Number of slots carved from one page of each class.
    localparam logic [SLOT_W-1:0] SLOT_COUNT [SIZE_CLASSES] = '{
        8'd254, 8'd127, 8'd63, 8'd31, 8'd16, 8'd8, 8'd4, 8'd1
    };

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd3;
    localparam logic [2:0] ST_NULL_REL   = 3'd4;
    localparam logic [2:0] ST_MISPLACED  = 3'd5;

    localparam logic REG_USABLE_PAGES = 1'b0;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [6:0]         older;
        logic [SLOT_W-1:0]  head;
    } page_entry_t;

    typedef struct packed {
        logic                done;
        logic [11:0]         quo;
        logic [BYTES_W-1:0]  rem;
    } div_result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK_RD,
        S_WALK_CHK,
        S_POP_RD,
        S_POP_WR,
        S_CLAIM,
        S_CARVE,
        S_CARVE_END,
        S_ADDR,
        S_REL_RD,
        S_REL_START,
        S_REL_DIV,
        S_REL_CHK,
        S_DONE
    } state_t;

endpackage

// ===== design/sca_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// It has no dependencies.
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sca_divider.sv =====
`timescale 1ns / 1ps
// Divider of slot offsets by class sizes through multiplication with a class reciprocal.
// Operands are taken at start; done rises after ph1 and ph2. It depends on sca_pkg.
module sca_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [11:0]                  dividend,
    input  logic [sca_pkg::BYTES_W-1:0]  divisor,
    output sca_pkg::div_result_t         result
);

    logic                          ph1_reg, ph1_next;
    logic                          ph2_reg, ph2_next;
    logic                          done_reg, done_next;
    logic [11:0]                   dvd_reg, dvd_next;
    logic [sca_pkg::BYTES_W-1:0]   dvs_reg, dvs_next;
    logic [sca_pkg::RECIP_W-1:0]   rcp_reg, rcp_next;
    logic [11:0]                   quo_reg, quo_next;
    logic [sca_pkg::BYTES_W-1:0]   rem_reg, rem_next;
    logic [sca_pkg::RECIP_W-1:0]   recip;
    logic [sca_pkg::RECIP_W+11:0]  scaled;
    logic [11:0]                   back;
    logic [11:0]                   diff;

    always_comb begin
        recip = '0;
        for (int i = 0; i < sca_pkg::SIZE_CLASSES; i++) begin
            if (divisor == sca_pkg::CLASS_BYTES[i]) begin
                recip = sca_pkg::CLASS_RECIP[i];
            end
        end
    end

    assign scaled = {{sca_pkg::RECIP_W{1'b0}}, dvd_reg} * {12'd0, rcp_reg};
    assign back   = quo_reg * {1'b0, dvs_reg};
    assign diff   = dvd_reg - back;

    always_comb begin
        ph1_next  = 1'b0;
        ph2_next  = 1'b0;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rcp_next  = rcp_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            ph1_next = 1'b1;
            dvd_next = dividend;
            dvs_next = divisor;
            rcp_next = recip;
        end
        if (ph1_reg) begin
            ph2_next = 1'b1;
            quo_next = {3'd0, scaled[sca_pkg::RECIP_W+11:sca_pkg::RECIP_SHIFT]};
        end
        if (ph2_reg) begin
            done_next = 1'b1;
            rem_next  = diff[sca_pkg::BYTES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rcp_reg <= rcp_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign result.done = done_reg;
    assign result.quo  = quo_reg;
    assign result.rem  = rem_reg;

endmodule

// ===== design/size_class_block_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the size class block allocator: sequencer, page and slot tables, APB port.
// It depends on sca_pkg, sca_ram and sca_divider.

// An allocation that finds a free slot on its class's newest page passes the decode, walk
// read, walk check, pop read, pop write and address states before it gives its result, and
// the block is ready again in the cycle after the result is taken. Each full page passed on
// the walk adds a walk read and a walk check, one page table read. Claiming a new page carves
// it by writing one slot link per cycle into the slot table, then writes the page entry and
// forms the address, after any walk. A release that reaches the slot check passes the page
// read and divider start states and waits on the reciprocal divider that turns the offset
// into a slot index. Zero size, oversized, null and out of range releases give their result
// straight from decode. One transaction is in work at a time, and the slot table needs no
// clearing pass after reset.
module size_class_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [11:0] s_request_size,
    input  logic [17:0] s_release_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [17:0] m_block_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sca_pkg::state_t state_reg, state_next;

    logic        cmd_reg;
    logic [11:0] size_reg;
    logic [17:0] rel_addr_reg;
    logic [6:0]  usable_reg;
    logic [6:0]  claimed_reg, claimed_next;
    logic [6:0]  newest_reg [sca_pkg::SIZE_CLASSES];
    logic [6:0]  newest_next [sca_pkg::SIZE_CLASSES];
    logic [6:0]  cur_pg_reg, cur_pg_next;
    logic [2:0]  cls_reg, cls_next;
    logic [7:0]  slot_reg, slot_next;
    logic [7:0]  idx_reg, idx_next;
    logic [2:0]  status_reg, status_next;
    logic [17:0] addr_reg, addr_next;

    logic [3:0]  lookup_cls;
    logic [6:0]  limit;
    logic [6:0]  newest_sel;
    logic [7:0]  carve_cnt;
    logic [11:0] prod;
    logic [11:0] offset;

    logic                 page_we;
    sca_pkg::page_entry_t page_wdata, page_rdata;
    logic                 slot_we;
    logic [13:0]          slot_waddr;
    logic [7:0]           slot_wdata, slot_rdata;
    logic                 div_start;
    sca_pkg::div_result_t div_res;

    logic cfg_write;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == sca_pkg::REG_USABLE_PAGES) ? {25'd0, usable_reg} : 32'd0;

    always_comb begin
        lookup_cls = 4'd0;
        for (int i = 0; i < sca_pkg::SIZE_CLASSES; i++) begin
            if (size_reg > {1'b0, sca_pkg::CLASS_BYTES[i]}) begin
                lookup_cls = lookup_cls + 4'd1;
            end
        end
    end

    assign limit      = (usable_reg < sca_pkg::NO_PAGE) ? usable_reg : sca_pkg::NO_PAGE;
    assign newest_sel = newest_reg[lookup_cls[2:0]];
    assign carve_cnt  = sca_pkg::SLOT_COUNT[cls_reg];
    assign prod       = {4'd0, slot_reg} * {1'b0, sca_pkg::CLASS_BYTES[cls_reg]};
    assign offset     = rel_addr_reg[11:0];

    sca_ram #(
        .WIDTH($bits(sca_pkg::page_entry_t)),
        .DEPTH(sca_pkg::POOL_PAGES)
    ) u_page_ram (
        .aclk (aclk),
        .we   (page_we),
        .waddr(cur_pg_reg[sca_pkg::PAGE_W-1:0]),
        .wdata(page_wdata),
        .raddr(cur_pg_reg[sca_pkg::PAGE_W-1:0]),
        .rdata(page_rdata)
    );

    sca_ram #(
        .WIDTH(sca_pkg::SLOT_W),
        .DEPTH(sca_pkg::POOL_PAGES * 256)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr({cur_pg_reg[sca_pkg::PAGE_W-1:0], slot_reg}),
        .rdata(slot_rdata)
    );

    sca_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(offset - sca_pkg::SLOT_BASE),
        .divisor (sca_pkg::CLASS_BYTES[page_rdata.cls]),
        .result  (div_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sca_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = sca_pkg::S_DECODE;
                end
            end
            sca_pkg::S_DECODE: begin
                if (cmd_reg == sca_pkg::CMD_ALLOC) begin
                    if (size_reg == 12'd0 || lookup_cls[3]) begin
                        state_next = sca_pkg::S_DONE;
                    end else if (newest_sel == sca_pkg::NO_PAGE) begin
                        state_next = sca_pkg::S_CLAIM;
                    end else begin
                        state_next = sca_pkg::S_WALK_RD;
                    end
                end else if (rel_addr_reg == 18'd0) begin
                    state_next = sca_pkg::S_DONE;
                end else if ({1'b0, rel_addr_reg[17:12]} < claimed_reg
                             && offset >= sca_pkg::SLOT_BASE) begin
                    state_next = sca_pkg::S_REL_RD;
                end else begin
                    state_next = sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_WALK_RD:   state_next = sca_pkg::S_WALK_CHK;
            sca_pkg::S_WALK_CHK: begin
                if (page_rdata.head != sca_pkg::NO_SLOT) begin
                    state_next = sca_pkg::S_POP_RD;
                end else if (page_rdata.older == sca_pkg::NO_PAGE) begin
                    state_next = sca_pkg::S_CLAIM;
                end else begin
                    state_next = sca_pkg::S_WALK_RD;
                end
            end
            sca_pkg::S_POP_RD:    state_next = sca_pkg::S_POP_WR;
            sca_pkg::S_POP_WR:    state_next = sca_pkg::S_ADDR;
            sca_pkg::S_CLAIM: begin
                if (claimed_reg < limit) begin
                    state_next = sca_pkg::S_CARVE;
                end else begin
                    state_next = sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_CARVE: begin
                if (idx_reg == carve_cnt - 8'd1) begin
                    state_next = sca_pkg::S_CARVE_END;
                end
            end
            sca_pkg::S_CARVE_END: state_next = sca_pkg::S_ADDR;
            sca_pkg::S_ADDR:      state_next = sca_pkg::S_DONE;
            sca_pkg::S_REL_RD:    state_next = sca_pkg::S_REL_START;
            sca_pkg::S_REL_START: state_next = sca_pkg::S_REL_DIV;
            sca_pkg::S_REL_DIV: begin
                if (div_res.done) begin
                    state_next = sca_pkg::S_REL_CHK;
                end
            end
            sca_pkg::S_REL_CHK:   state_next = sca_pkg::S_DONE;
            sca_pkg::S_DONE: begin
                if (m_ready) begin
                    state_next = sca_pkg::S_IDLE;
                end
            end
            default:              state_next = sca_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        claimed_next = claimed_reg;
        newest_next  = newest_reg;
        cur_pg_next  = cur_pg_reg;
        cls_next     = cls_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;
        page_we      = 1'b0;
        page_wdata   = page_rdata;
        slot_we      = 1'b0;
        slot_waddr   = {cur_pg_reg[sca_pkg::PAGE_W-1:0], idx_reg};
        slot_wdata   = (idx_reg == 8'd0) ? sca_pkg::NO_SLOT : idx_reg - 8'd1;
        div_start    = 1'b0;
        case (state_reg)
            sca_pkg::S_DECODE: begin
                addr_next   = 18'd0;
                status_next = sca_pkg::ST_MISPLACED;
                cls_next    = lookup_cls[2:0];
                cur_pg_next = newest_sel;
                if (cmd_reg == sca_pkg::CMD_ALLOC) begin
                    if (size_reg == 12'd0) begin
                        status_next = sca_pkg::ST_ZERO_SIZE;
                    end else if (lookup_cls[3]) begin
                        status_next = sca_pkg::ST_TOO_LARGE;
                    end
                end else if (rel_addr_reg == 18'd0) begin
                    status_next = sca_pkg::ST_NULL_REL;
                end else begin
                    cur_pg_next = {1'b0, rel_addr_reg[17:12]};
                end
            end
            sca_pkg::S_WALK_CHK: begin
                slot_next = page_rdata.head;
                if (page_rdata.head == sca_pkg::NO_SLOT) begin
                    cur_pg_next = page_rdata.older;
                end
            end
            sca_pkg::S_POP_WR: begin
                page_we         = 1'b1;
                page_wdata.head = slot_rdata;
            end
            sca_pkg::S_CLAIM: begin
                idx_next    = 8'd0;
                cur_pg_next = claimed_reg;
                status_next = sca_pkg::ST_EXHAUSTED;
            end
            sca_pkg::S_CARVE: begin
                slot_we  = 1'b1;
                idx_next = idx_reg + 8'd1;
            end
            sca_pkg::S_CARVE_END: begin
                page_we          = 1'b1;
                page_wdata.cls   = cls_reg;
                page_wdata.older = newest_reg[cls_reg];
                page_wdata.head  = (carve_cnt == 8'd1) ? sca_pkg::NO_SLOT : carve_cnt - 8'd2;
                newest_next[cls_reg] = cur_pg_reg;
                claimed_next     = claimed_reg + 7'd1;
                slot_next        = carve_cnt - 8'd1;
            end
            sca_pkg::S_ADDR: begin
                status_next = sca_pkg::ST_OK;
                addr_next   = {cur_pg_reg[sca_pkg::PAGE_W-1:0], sca_pkg::SLOT_BASE + prod};
            end
            sca_pkg::S_REL_START: begin
                div_start = 1'b1;
                cls_next  = page_rdata.cls;
            end
            sca_pkg::S_REL_CHK: begin
                if (div_res.rem == '0 && div_res.quo < {4'd0, carve_cnt}) begin
                    slot_we         = 1'b1;
                    slot_waddr      = {cur_pg_reg[sca_pkg::PAGE_W-1:0], div_res.quo[7:0]};
                    slot_wdata      = page_rdata.head;
                    page_we         = 1'b1;
                    page_wdata.head = div_res.quo[7:0];
                    status_next     = sca_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sca_pkg::S_IDLE;
            usable_reg  <= 7'd64;
            claimed_reg <= 7'd0;
            for (int i = 0; i < sca_pkg::SIZE_CLASSES; i++) begin
                newest_reg[i] <= sca_pkg::NO_PAGE;
            end
        end else begin
            state_reg   <= state_next;
            claimed_reg <= claimed_next;
            newest_reg  <= newest_next;
            if (cfg_write && paddr[2] == sca_pkg::REG_USABLE_PAGES) begin
                usable_reg <= pwdata[6:0];
            end
        end
        if (s_valid && s_ready) begin
            cmd_reg      <= s_command;
            size_reg     <= s_request_size;
            rel_addr_reg <= s_release_address;
        end
        cur_pg_reg <= cur_pg_next;
        cls_reg    <= cls_next;
        slot_reg   <= slot_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    assign s_ready         = (state_reg == sca_pkg::S_IDLE);
    assign m_valid         = (state_reg == sca_pkg::S_DONE);
    assign m_status        = status_reg;
    assign m_block_address = addr_reg;

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input ready while a result is pending");

    a_claim_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        claimed_reg <= sca_pkg::NO_PAGE) else $error("claimed page count out of range");

    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sca_pkg::S_IDLE) |-> (!page_we && !slot_we))
        else $error("table write while idle");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready right after a transaction");

endmodule
